### hw/rtl/srdf_pkg.sv
package srdf_pkg;

	// SLIP special codes
	localparam logic [7:0] BYTE_END     = 8'hC0;
	localparam logic [7:0] BYTE_ESC     = 8'hDB;
	localparam logic [7:0] BYTE_ESC_END = 8'hDC;
	localparam logic [7:0] BYTE_ESC_ESC = 8'hDD;

	localparam logic [15:0] TIMEOUT_RESET  = 16'd50;
	localparam logic [15:0] TICKS_MAX      = 16'hFFFF;
	localparam int          FIFO_DEPTH_DEF = 64;

	typedef enum logic [1:0] {
		CMD_RX_BYTE  = 2'd0,
		CMD_RX_ERROR = 2'd1,
		CMD_READ     = 2'd2,
		CMD_TICK     = 2'd3
	} cmd_t;

	// one result from the control stage
	typedef struct packed {
		logic       valid;
		logic       empty;    // read found no byte before the timeout
		logic       from_mem; // data comes from the FIFO read port
		logic [7:0] data;     // bypass byte (or zero)
	} res_t;

endpackage

### hw/rtl/slip_receive_decoder_fifo.sv
// Channel   Direction  tdata            tuser
// s_axis    in         [7:0] rx_byte    [1:0] command (rx byte/error/read/tick)
// m_axis    out        [7:0] read_data  [0] read_empty
// cfg       in         cfg_wr_data[15:0] = read timeout in ticks, no read-back
//
// One transaction per cycle while m_axis does not stall; a result, if any, passes
// the input register, then the result register, on its way to m_axis.
// The FIFO read port is registered, so popped data is muxed in at the output.
// arst_n clears flags, pointers, counters and sets the timeout to 50 ticks.
// An m_axis stall holds both stages; s_axis stays ready while stage 1 is
// empty or moving on.
module slip_receive_decoder_fifo #(
	parameter int FIFO_DEPTH = srdf_pkg::FIFO_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  logic [1:0]  s_axis_tuser,   // [1:0] command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] read_data
	output logic [0:0]  m_axis_tuser,   // [0] read_empty
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data
);
	import srdf_pkg::*;

	localparam int AW = $clog2(FIFO_DEPTH);

	logic [15:0]   timeout_q;

	// stage 1: accepted transaction
	logic          valid_s1;
	cmd_t          cmd_s1;
	logic [7:0]    byte_s1;

	// stage 2: result register
	logic          valid_s2;
	logic          empty_s2;
	logic          from_mem_s2;
	logic [7:0]    byte_s2;

	logic          advance;
	logic          item_en;
	res_t          res;
	logic          wr_en, rd_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [7:0]    wr_data, rd_data;

	// stage 1 moves on when the result register is free or being drained
	assign advance       = !valid_s2 || m_axis_tready;
	assign item_en       = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_wr_en) begin
			timeout_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1  <= cmd_t'(s_axis_tuser);
			byte_s1 <= s_axis_tdata;
		end
	end

	srdf_ctrl #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.item_en (item_en),
		.cmd     (cmd_s1),
		.rx_byte (byte_s1),
		.timeout (timeout_q),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.res     (res)
	);

	// read data register inside updates only with a pop, which also loads stage 2
	srdf_mem #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			empty_s2    <= res.empty;
			from_mem_s2 <= res.from_mem;
			byte_s2     <= res.data;
		end
	end

	assign m_axis_tvalid   = valid_s2;
	assign m_axis_tdata    = from_mem_s2 ? rd_data : byte_s2;
	assign m_axis_tuser[0] = empty_s2;

endmodule

### hw/rtl/srdf_mem.sv
module srdf_mem #(
	parameter int FIFO_DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [$clog2(FIFO_DEPTH)-1:0] wr_addr,
	input  logic [7:0]                    wr_data,
	input  logic                          rd_en,
	input  logic [$clog2(FIFO_DEPTH)-1:0] rd_addr,
	output logic [7:0]                    rd_data
);

	logic [7:0] mem [FIFO_DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### hw/rtl/srdf_ctrl.sv
module srdf_ctrl #(
	parameter int FIFO_DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_en,
	input  srdf_pkg::cmd_t                cmd,
	input  logic [7:0]                    rx_byte,
	input  logic [15:0]                   timeout,
	output logic                          wr_en,
	output logic [$clog2(FIFO_DEPTH)-1:0] wr_addr,
	output logic [7:0]                    wr_data,
	output logic                          rd_en,
	output logic [$clog2(FIFO_DEPTH)-1:0] rd_addr,
	output srdf_pkg::res_t                res
);
	import srdf_pkg::*;

	localparam int AW = $clog2(FIFO_DEPTH);
	localparam int CW = $clog2(FIFO_DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(FIFO_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(FIFO_DEPTH);

	logic          esc_q, esc_d;
	logic [AW-1:0] widx_q, widx_d;
	logic [AW-1:0] ridx_q, ridx_d;
	logic [CW-1:0] fill_q, fill_d;
	logic          wait_q, wait_d;
	logic [15:0]   ticks_q, ticks_d;

	logic          push_req;
	logic [7:0]    dec_byte;
	logic [15:0]   ticks_inc;

	// decode one received byte
	always_comb begin
		push_req = (rx_byte != BYTE_END) && (rx_byte != BYTE_ESC);
		dec_byte = rx_byte;
		if (esc_q && rx_byte == BYTE_ESC_END) begin
			dec_byte = BYTE_END;
		end else if (esc_q && rx_byte == BYTE_ESC_ESC) begin
			dec_byte = BYTE_ESC;
		end
		ticks_inc = (ticks_q == TICKS_MAX) ? ticks_q : ticks_q + 16'd1;
	end

	always_comb begin
		esc_d   = esc_q;
		widx_d  = widx_q;
		ridx_d  = ridx_q;
		fill_d  = fill_q;
		wait_d  = wait_q;
		ticks_d = ticks_q;
		wr_en   = 1'b0;
		rd_en   = 1'b0;
		res     = '0;
		if (item_en) begin
			case (cmd)
				CMD_RX_BYTE: begin
					if (rx_byte == BYTE_ESC) begin
						esc_d = 1'b1;
					end else if (push_req) begin
						esc_d = 1'b0;
					end
					if (push_req) begin
						if (wait_q) begin
							// FIFO is empty while waiting: hand byte straight out
							wait_d    = 1'b0;
							res.valid = 1'b1;
							res.data  = dec_byte;
						end else if (fill_q < FULL_CNT) begin
							wr_en  = 1'b1;
							widx_d = (widx_q == LAST_IDX) ? '0 : widx_q + AW'(1);
							fill_d = fill_q + CW'(1);
						end
					end
				end
				CMD_READ: begin
					if (!wait_q) begin
						if (fill_q != '0) begin
							rd_en        = 1'b1;
							ridx_d       = (ridx_q == LAST_IDX) ? '0 : ridx_q + AW'(1);
							fill_d       = fill_q - CW'(1);
							res.valid    = 1'b1;
							res.from_mem = 1'b1;
						end else if (timeout == '0) begin
							res.valid = 1'b1;
							res.empty = 1'b1;
						end else begin
							wait_d  = 1'b1;
							ticks_d = '0;
						end
					end
				end
				CMD_TICK: begin
					if (wait_q) begin
						ticks_d = ticks_inc;
						if (ticks_inc >= timeout) begin
							wait_d    = 1'b0;
							res.valid = 1'b1;
							res.empty = 1'b1;
						end
					end
				end
				default: begin
					// receive error: byte dropped, nothing changes
				end
			endcase
		end
	end

	assign wr_addr = widx_q;
	assign wr_data = dec_byte;
	assign rd_addr = ridx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q   <= 1'b0;
			widx_q  <= '0;
			ridx_q  <= '0;
			fill_q  <= '0;
			wait_q  <= 1'b0;
			ticks_q <= '0;
		end else begin
			esc_q   <= esc_d;
			widx_q  <= widx_d;
			ridx_q  <= ridx_d;
			fill_q  <= fill_d;
			wait_q  <= wait_d;
			ticks_q <= ticks_d;
		end
	end

endmodule
